[hw/rtl/bdqs_pkg.sv]
`default_nettype none

package bdqs_pkg;

  // default ring depth and word width
  localparam int BDQS_DEPTH = 16;
  localparam int WORD_W     = 32;

  // operation codes carried by in_kind
  typedef enum logic [2:0] {
    K_INS_FRONT = 3'd0,
    K_INS_BACK  = 3'd1,
    K_REM_FRONT = 3'd2,
    K_REM_BACK  = 3'd3,
    K_COUNT     = 3'd4,
    K_SEARCH    = 3'd5
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SEARCH,
    S_DONE
  } state_t;

  // commands broadcast from the sequencer to every cell
  typedef struct packed {
    logic shift_right;  // insert at front: every cell takes its left neighbour
    logic shift_left;   // remove at front: every cell takes its right neighbour
    logic load_back;    // insert at back: the cell at the count takes the word
    logic hit_clr;      // start of a search
    logic hit_step;     // one step of the match ripple
  } ctrl_t;

endpackage

`default_nettype wire

[hw/rtl/bdqs_cell.sv]
`default_nettype none

module bdqs_cell
  import bdqs_pkg::*;
#(
  parameter int NW    = $clog2(BDQS_DEPTH + 1),
  parameter int INDEX = 0
) (
  input  wire logic                     clk,
  input  wire ctrl_t                    ctrl,
  input  wire logic [NW-1:0]            count,
  input  wire logic signed [WORD_W-1:0] left_in,
  input  wire logic signed [WORD_W-1:0] right_in,
  input  wire logic signed [WORD_W-1:0] wr_data,
  input  wire logic signed [WORD_W-1:0] key,
  input  wire logic                     hit_in,
  output logic signed [WORD_W-1:0]      data_out,
  output logic                          hit_out
);

  logic signed [WORD_W-1:0] data_r, data_nxt;
  logic                     hit_r, hit_nxt;
  logic                     occupied;

  // this cell holds an element when its position lies below the count
  assign occupied = NW'(INDEX) < count;

  // word movement along the row
  always_comb begin
    data_nxt = data_r;
    if (ctrl.shift_right) begin
      data_nxt = left_in;
    end else if (ctrl.shift_left) begin
      data_nxt = right_in;
    end else if (ctrl.load_back && (count == NW'(INDEX))) begin
      data_nxt = wr_data;
    end
  end

  // match ripple: OR of all matches from the front up to this cell
  always_comb begin
    hit_nxt = hit_r;
    if (ctrl.hit_clr) begin
      hit_nxt = 1'b0;
    end else if (ctrl.hit_step) begin
      hit_nxt = hit_in | (occupied & (data_r == key));
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    hit_r  <= hit_nxt;
  end

  assign data_out = data_r;
  assign hit_out  = hit_r;

endmodule

`default_nettype wire

[hw/rtl/bounded_deque_with_search_unit.sv]
// Channel   Direction  Handshake            Word
// in_       input      in_valid/in_stall    in_kind, in_value
// out_      output     out_valid/out_stall  out_status, out_data, out_count
//
// Inserts, removals, count and unused kinds finish in the cycle they are taken;
// the result is registered and appears in the next cycle.
// A search on a non-empty list steps through S_SEARCH and then S_DONE: the match flag ripples
// through the row of DEPTH cells, one cell per cycle.
// One word is in flight at a time; in_stall is high while a search runs or
// while an earlier result is still held by out_stall.
// rst_n is synchronous, active low; it empties the list. Cell contents are not reset.
`default_nettype none

module bounded_deque_with_search_unit
  import bdqs_pkg::*;
#(
  parameter  int DEPTH = BDQS_DEPTH,
  localparam int NW    = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [2:0]               in_kind,
  input  wire logic signed [WORD_W-1:0] in_value,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [1:0]                    out_status,
  output logic signed [WORD_W-1:0]      out_data,
  output logic [NW-1:0]                 out_count
);

  localparam int CW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  state_t                   state_r, state_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [NW-1:0]            count_r, count_nxt;
  logic signed [WORD_W-1:0] key_r, key_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r;
  logic signed [WORD_W-1:0] out_data_r;
  logic [NW-1:0]            out_count_r;

  ctrl_t                    ctrl;
  logic                     load_out;
  status_t                  res_status;
  logic signed [WORD_W-1:0] res_data;
  logic                     out_free, accept, full, empty, hit_last;

  logic signed [WORD_W-1:0] cell_data [DEPTH];
  logic                     cell_hit  [DEPTH];

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign full     = count_r == NW'(DEPTH);
  assign empty    = count_r == '0;
  assign hit_last = cell_hit[DEPTH-1];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == K_SEARCH) && !empty) begin
          state_nxt = S_SEARCH;
        end
      end
      S_SEARCH: begin
        if (cnt_r == CW'(DEPTH - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    ctrl       = '0;
    count_nxt  = count_r;
    cnt_nxt    = cnt_r;
    key_nxt    = key_r;
    load_out   = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          load_out = 1'b1;
          unique case (in_kind)
            K_INS_FRONT: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.shift_right = 1'b1;
                count_nxt        = count_r + NW'(1);
              end
            end
            K_INS_BACK: begin
              if (full) begin
                res_status = ST_FULL;
              end else begin
                ctrl.load_back = 1'b1;
                count_nxt      = count_r + NW'(1);
              end
            end
            K_REM_FRONT: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                ctrl.shift_left = 1'b1;
                count_nxt       = count_r - NW'(1);
              end
            end
            K_REM_BACK: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                count_nxt = count_r - NW'(1);
              end
            end
            K_SEARCH: begin
              if (empty) begin
                res_status = ST_EMPTY;
              end else begin
                load_out     = 1'b0;
                ctrl.hit_clr = 1'b1;
                key_nxt      = in_value;
                cnt_nxt      = '0;
              end
            end
            default: ;  // count and unused kinds change nothing
          endcase
        end
      end
      S_SEARCH: begin
        ctrl.hit_step = 1'b1;
        cnt_nxt       = cnt_r + CW'(1);
      end
      S_DONE: begin
        if (out_free) begin
          load_out   = 1'b1;
          res_status = hit_last ? ST_OK : ST_NOTFOUND;
          res_data   = hit_last ? key_r : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_nxt = load_out || (out_valid_r && out_stall);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    if (load_out) begin
      out_status_r <= res_status;
      out_data_r   <= res_data;
      out_count_r  <= count_nxt;
    end
  end

  // row of cells, front at position 0
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WORD_W-1:0] left_w, right_w;
    logic                     hit_in_w;

    if (i == 0) begin : g_front
      assign left_w   = in_value;
      assign hit_in_w = 1'b0;
    end else begin : g_mid
      assign left_w   = cell_data[i-1];
      assign hit_in_w = cell_hit[i-1];
    end

    if (i == DEPTH - 1) begin : g_back
      assign right_w = '0;
    end else begin : g_inner
      assign right_w = cell_data[i+1];
    end

    bdqs_cell #(
      .NW    (NW),
      .INDEX (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .count    (count_r),
      .left_in  (left_w),
      .right_in (right_w),
      .wr_data  (in_value),
      .key      (key_r),
      .hit_in   (hit_in_w),
      .data_out (cell_data[i]),
      .hit_out  (cell_hit[i])
    );
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_data   = out_data_r;
  assign out_count  = out_count_r;

endmodule

`default_nettype wire

[hw/rtl/bdqs_checker.sv]
`default_nettype none

module bdqs_checker
  import bdqs_pkg::*;
#(
  parameter  int DEPTH = BDQS_DEPTH,
  localparam int NW    = $clog2(DEPTH + 1)
) (
  input wire logic                     clk,
  input wire logic                     rst_n,
  input wire logic                     in_valid,
  input wire logic                     in_stall,
  input wire logic [2:0]               in_kind,
  input wire logic                     out_valid,
  input wire logic                     out_stall,
  input wire logic [1:0]               out_status,
  input wire logic signed [WORD_W-1:0] out_data,
  input wire logic [NW-1:0]            out_count
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_status)
      && $stable(out_count))
    else $error("stalled result word changed");

  // one word in flight: no input taken while a result is held back
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_count <= NW'(DEPTH))
    else $error("count beyond depth");

  // data is zero on every failing status
  a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> out_data == '0)
    else $error("data set on failing status");

  // anything but a search gives its result in the next cycle
  a_fast_ops: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind != K_SEARCH) |=> out_valid)
    else $error("short operation result late");

endmodule

bind bounded_deque_with_search_unit bdqs_checker #(.DEPTH(DEPTH)) u_bdqs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .in_kind    (in_kind),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_status (out_status),
  .out_data   (out_data),
  .out_count  (out_count)
);

`default_nettype wire

[tb/sv/testbench.sv]
`default_nettype none

module testbench;
  import bdqs_pkg::*;

  localparam int DEPTH      = BDQS_DEPTH;
  localparam int NW         = $clog2(DEPTH + 1);
  localparam int RAND_WORDS = 1100;
  localparam int CALM_TAIL  = 150;
  localparam int MAX_CYCLES = 400000;

  // kinds the block treats as no operation
  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic [2:0]               in_kind;
  logic signed [WORD_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall;
  logic [1:0]               out_status;
  logic signed [WORD_W-1:0] out_data;
  logic [NW-1:0]            out_count;

  bit in_idle_on;
  bit out_idle_on;
  int stall_left;
  int cycles;

  // one expected result word
  typedef struct {
    status_t       status;
    logic [31:0]   data;
    logic [NW-1:0] count;
  } deque_answer_t;

  // mirror of the ring contents plus the queue of answers still to come
  class deque_mirror;
    logic [31:0]   ring [DEPTH];
    int            head;
    int            fill;
    deque_answer_t answers_due [$];
    int            errors;
    int            n_words;
    int            n_hit;
    int            n_miss;
    int            n_full;
    int            n_empty;

    function logic [31:0] held_value(int idx);
      return ring[(head + idx) % DEPTH];
    endfunction

    // apply an accepted word to the mirror and queue its answer
    function void note_word(logic [2:0] kind, logic [31:0] value);
      deque_answer_t a;
      bit            found;
      a.status = ST_OK;
      a.data   = '0;
      found    = 1'b0;
      case (kind)
        K_INS_FRONT, K_INS_BACK: begin
          if (fill >= DEPTH) begin
            a.status = ST_FULL;
          end else if (kind == K_INS_FRONT) begin
            head       = (head + DEPTH - 1) % DEPTH;
            ring[head] = value;
            fill++;
          end else begin
            ring[(head + fill) % DEPTH] = value;
            fill++;
          end
        end
        K_REM_FRONT, K_REM_BACK: begin
          if (fill == 0) begin
            a.status = ST_EMPTY;
          end else begin
            if (kind == K_REM_FRONT) head = (head + 1) % DEPTH;
            fill--;
          end
        end
        K_SEARCH: begin
          if (fill == 0) begin
            a.status = ST_EMPTY;
          end else begin
            for (int i = 0; i < fill; i++)
              if (held_value(i) == value) found = 1'b1;
            a.status = found ? ST_OK : ST_NOTFOUND;
            a.data   = found ? value : '0;
            if (found) n_hit++;
            else n_miss++;
          end
        end
        default: ;
      endcase
      a.count = fill[NW-1:0];
      if (a.status == ST_FULL) n_full++;
      if (a.status == ST_EMPTY) n_empty++;
      n_words++;
      answers_due.push_back(a);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
      $display("mismatch on %s: got %0h, expected %0h", field, got, want);
      errors++;
    endtask

    // compare one accepted result word with the oldest answer due
    task check_word(logic [1:0] status, logic [31:0] data, logic [NW-1:0] count);
      deque_answer_t a;
      if (answers_due.size() == 0) begin
        report("unexpected result", {30'd0, status}, '0);
      end else begin
        a = answers_due.pop_front();
        if (status !== a.status) report("status", {30'd0, status}, {30'd0, a.status});
        if (data !== a.data) report("data", data, a.data);
        if (count !== a.count) report("count", 32'(count), 32'(a.count));
      end
    endtask
  endclass

  deque_mirror mirror;

  bounded_deque_with_search_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_kind    (in_kind),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_status (out_status),
    .out_data   (out_data),
    .out_count  (out_count)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYCLES) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stall bursts
  always @(posedge clk) begin
    if (!rst_n || !out_idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      mirror.check_word(out_status, out_data, out_count);
  end

  // offer one word, with an optional idle burst first, and wait for it to be taken
  task automatic send_word(input logic [2:0] kind, input logic [31:0] value);
    if (in_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_value <= value;
    do @(posedge clk); while (in_stall !== 1'b0);
    mirror.note_word(kind, value);
  endtask

  // extremes, a few small values that repeat, and plain random words
  function automatic logic [31:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      case ($urandom_range(0, 3))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'h0000_0000;
        default: return 32'hffff_ffff;
      endcase
    end
    if (r < 40) return $urandom_range(0, 7);
    return $urandom;
  endfunction

  task automatic random_word(input int grow_pct, output logic [2:0] kind,
                             output logic [31:0] value);
    int r;
    r     = $urandom_range(0, 99);
    value = pick_value();
    if (r < 3) begin
      kind = $urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B;
    end else if (r < 8) begin
      kind = K_COUNT;
    end else if (r < 30) begin
      kind = K_SEARCH;
      // mostly look for something that is held, at any depth
      if (mirror.fill != 0 && $urandom_range(0, 9) < 6)
        value = mirror.held_value($urandom_range(0, mirror.fill - 1));
    end else if ($urandom_range(0, 99) < grow_pct) begin
      kind = $urandom_range(0, 1) ? K_INS_FRONT : K_INS_BACK;
    end else begin
      kind = $urandom_range(0, 1) ? K_REM_FRONT : K_REM_BACK;
    end
  endtask

  initial begin
    int          sent;
    int          phase_len;
    int          grow_pct;
    logic [2:0]  kind;
    logic [31:0] value;

    mirror      = new();
    in_idle_on  = 1'b0;
    out_idle_on = 1'b0;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_kind    <= K_COUNT;
    in_value   <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty refusals, spare kinds, single-element removals, searches
    send_word(K_REM_FRONT, $urandom);
    send_word(K_REM_BACK, $urandom);
    send_word(K_SEARCH, 32'h0);
    send_word(K_COUNT, $urandom);
    send_word(KIND_SPARE_A, $urandom);
    send_word(KIND_SPARE_B, $urandom);
    send_word(K_INS_FRONT, 32'h7fff_ffff);
    send_word(K_REM_BACK, $urandom);
    send_word(K_INS_BACK, 32'h8000_0000);
    send_word(K_REM_FRONT, $urandom);
    send_word(K_INS_FRONT, 32'h8000_0000);
    send_word(K_INS_BACK, 32'h7fff_ffff);
    send_word(K_INS_FRONT, 32'hffff_ffff);
    send_word(K_SEARCH, 32'h0);
    send_word(K_INS_BACK, 32'h0);
    send_word(K_SEARCH, 32'h0);
    send_word(K_SEARCH, 32'hffff_ffff);
    send_word(K_SEARCH, 32'h8000_0000);
    send_word(K_SEARCH, 32'h1234_5678);
    send_word(K_COUNT, $urandom);
    send_word(K_REM_FRONT, $urandom);
    send_word(K_REM_BACK, $urandom);

    // random: phases that lean towards growing, shrinking or neither
    sent = 0;
    while (sent < RAND_WORDS) begin
      phase_len = $urandom_range(40, 120);
      case ($urandom_range(0, 2))
        0: grow_pct = 85;
        1: grow_pct = 15;
        default: grow_pct = 50;
      endcase
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      for (int n = 0; n < phase_len && sent < RAND_WORDS; n++) begin
        if (sent >= RAND_WORDS - CALM_TAIL) begin
          in_idle_on  = 1'b0;
          out_idle_on = 1'b0;
        end
        random_word(grow_pct, kind, value);
        send_word(kind, value);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // drain, then give stray results time to show up
    while (mirror.answers_due.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 4) @(posedge clk);

    $display("covered %0d words: %0d search hits, %0d search misses,", mirror.n_words,
             mirror.n_hit, mirror.n_miss);
    $display("%0d full and %0d empty refusals, %0d mismatches", mirror.n_full,
             mirror.n_empty, mirror.errors);
    if (mirror.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

[bounded_deque_with_search_unit.f]
hw/rtl/bdqs_pkg.sv
hw/rtl/bdqs_cell.sv
hw/rtl/bounded_deque_with_search_unit.sv
hw/rtl/bdqs_checker.sv
tb/sv/testbench.sv
